// File: hdl/pmpe_pkg.sv
`default_nettype none

package pmpe_pkg;

	// Characters that steer the evaluation.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam int unsigned WORD_W = 32;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		ST_OK              = 2'd0,
		ST_OVERFLOW        = 2'd1,
		ST_UNMATCHED_CLOSE = 2'd2,
		ST_UNCLOSED_OPEN   = 2'd3
	} status_t;

endpackage : pmpe_pkg

`default_nettype wire

// File: hdl/plus_minus_paren_evaluator_unit.sv
// Expression evaluator for decimal numbers, '+', '-', '(' and ')'.
// The input channel (char_valid, char_stall, char_code, last) carries one
// ASCII character per transfer; last marks the final character of an
// expression. Every other character, spaces included, only ends a number.
// The result channel (res_valid, res_stall, value, status) carries one
// transfer per expression: the 32-bit wrapped value and a status code
// (ok, nesting overflow, unmatched close, unclosed open; the first error wins).
// A character is taken every cycle while char_stall is low. It waits in
// the input register and is then folded into the evaluation state; the
// result of an expression is registered in the result register when its
// last character is folded in. The single-cycle rate is set by the
// evaluation step: the running sum update and one access of the nesting
// stack memory, whose top entry and next entry are held in registers.
// While a result waits under res_stall, characters keep flowing until a
// second last character reaches the input register; char_stall is then
// raised until the pending result is transferred out.
// Reset (arst_n low) empties the pipeline and clears the evaluation state;
// the stack memory itself is not cleared, only the nesting level.
`default_nettype none

module plus_minus_paren_evaluator_unit
	import pmpe_pkg::*;
#(
	parameter int unsigned NEST_DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,

	input  wire logic         char_valid,
	output logic              char_stall,
	input  wire logic [7:0]   char_code,
	input  wire logic         last,

	output logic              res_valid,
	input  wire logic         res_stall,
	output logic signed [31:0] value,
	output logic [1:0]        status
);

	// Level counter must reach NEST_DEPTH itself; the memory holds the
	// entries below the top one.
	localparam int unsigned LW        = $clog2(NEST_DEPTH + 1);
	localparam int unsigned AW        = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int unsigned MEM_DEPTH = 1 << AW;

	// Input register stage.
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	// Evaluation state.
	word_t       sum_q;
	logic        sign_q;
	word_t       pend_q;
	logic [LW-1:0] level_q;
	status_t     err_q;

	// Stack: top entry in registers, the one below it prefetched from memory.
	word_t       top_sum_q;
	logic        top_sign_q;
	word_t       rd_sum_q;
	logic        rd_sign_q;
	word_t       mem_sum [MEM_DEPTH];
	logic        mem_sign [MEM_DEPTH];

	// Result register.
	logic        out_valid_q;
	word_t       value_q;
	status_t     status_q;

	logic        blocked;
	logic        proc;

	// A last character may not be handled while the previous result is
	// still waiting for its transfer.
	assign blocked    = valid_s1 && last_s1 && out_valid_q && res_stall;
	assign proc       = valid_s1 && !blocked;
	assign char_stall = blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1 <= char_code;
			last_s1 <= last;
		end
	end

	// Combinational evaluation of the character in the input register.
	logic          is_digit;
	logic [3:0]    digit;
	word_t         pend_acc;
	word_t         sum_dig;
	word_t         sum_f;
	word_t         sum_chr;
	word_t         sum_n;
	logic          sign_n;
	word_t         pend_n;
	logic [LW-1:0] level_n;
	status_t       err_n;
	status_t       err_final;
	logic          push;
	logic          pop;

	always_comb begin
		is_digit = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
		digit    = 4'(char_s1 - CH_ZERO);
		pend_acc = (pend_q << 3) + (pend_q << 1) + word_t'(digit);

		// A last digit folds the extended number; any non-digit folds
		// the number as it stands. Both are formed side by side so that a
		// close only adds one more step after the fold.
		sum_dig  = sign_q ? (sum_q - pend_acc) : (sum_q + pend_acc);
		sum_chr  = sign_q ? (sum_q - pend_q) : (sum_q + pend_q);

		// Fold the pending number on any non-digit and on the last character.
		if (!is_digit) begin
			sum_f = sum_chr;
		end else if (last_s1) begin
			sum_f = sum_dig;
		end else begin
			sum_f = sum_q;
		end

		pend_n  = is_digit ? pend_acc : '0;
		sum_n   = sum_f;
		sign_n  = sign_q;
		level_n = level_q;
		err_n   = err_q;
		push    = 1'b0;
		pop     = 1'b0;

		if (!is_digit) begin
			case (char_s1)
				CH_PLUS: begin
					sign_n = 1'b0;
				end
				CH_MINUS: begin
					sign_n = 1'b1;
				end
				CH_OPEN: begin
					if (level_q == LW'(NEST_DEPTH)) begin
						if (err_q == ST_OK) err_n = ST_OVERFLOW;
					end else begin
						push    = 1'b1;
						level_n = level_q + LW'(1);
						sum_n   = '0;
						sign_n  = 1'b0;
					end
				end
				CH_CLOSE: begin
					if (level_q == '0) begin
						if (err_q == ST_OK) err_n = ST_UNMATCHED_CLOSE;
					end else begin
						pop     = 1'b1;
						level_n = level_q - LW'(1);
						// The inner sum is negated when the group had a minus sign.
						sum_n   = top_sign_q ? (top_sum_q - sum_chr) : (top_sum_q + sum_chr);
					end
				end
				default: begin
				end
			endcase
		end

		err_final = err_n;
		if ((level_n != '0) && (err_n == ST_OK)) err_final = ST_UNCLOSED_OPEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			sign_q  <= 1'b0;
			pend_q  <= '0;
			level_q <= '0;
			err_q   <= ST_OK;
		end else if (proc) begin
			if (last_s1) begin
				sum_q   <= '0;
				sign_q  <= 1'b0;
				pend_q  <= '0;
				level_q <= '0;
				err_q   <= ST_OK;
			end else begin
				sum_q   <= sum_n;
				sign_q  <= sign_n;
				pend_q  <= pend_n;
				level_q <= level_n;
				err_q   <= err_n;
			end
		end
	end

	// Stack memory. A push spills the old top entry to address level-1,
	// which is also the entry below the new top, hence the bypass into the
	// prefetch register. After a pop the prefetch reads the next entry down.
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] lvl_m1;
	logic [LW-1:0] lvl_n_m2;

	assign lvl_m1   = level_q - LW'(1);
	assign lvl_n_m2 = level_n - LW'(2);
	assign mem_we   = proc && !last_s1 && push && (level_q != '0);
	assign wr_addr  = lvl_m1[AW-1:0];
	assign rd_addr  = lvl_n_m2[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_sum[wr_addr]  <= top_sum_q;
			mem_sign[wr_addr] <= top_sign_q;
		end
		if (proc && !last_s1) begin
			if (mem_we && (wr_addr == rd_addr)) begin
				rd_sum_q  <= top_sum_q;
				rd_sign_q <= top_sign_q;
			end else begin
				rd_sum_q  <= mem_sum[rd_addr];
				rd_sign_q <= mem_sign[rd_addr];
			end
			if (push) begin
				top_sum_q  <= sum_f;
				top_sign_q <= sign_q;
			end else if (pop) begin
				top_sum_q  <= rd_sum_q;
				top_sign_q <= rd_sign_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			value_q  <= sum_n;
			status_q <= err_final;
		end
	end

	assign res_valid = out_valid_q;
	assign value     = signed'(value_q);
	assign status    = status_q;

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(NEST_DEPTH))
		else $error("nesting level beyond stack depth");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> (valid_s1 && last_s1 && out_valid_q))
		else $error("input stalled without a waiting result");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && last_s1) |=> (level_q == '0 && err_q == ST_OK && res_valid))
		else $error("state not cleared after last character");

	a_unmatched_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && !last_s1 && char_s1 == CH_CLOSE && level_q == '0)
		|=> (level_q == '0 && err_q != ST_OK))
		else $error("unmatched close not flagged");
`endif

endmodule : plus_minus_paren_evaluator_unit

`default_nettype wire

// File: bench/pmpe_checker.sv
`default_nettype none

module pmpe_checker
	import pmpe_pkg::*;
#(
	parameter int unsigned NEST_DEPTH = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         char_valid,
	input  wire logic         char_stall,
	input  wire logic [7:0]   char_code,
	input  wire logic         last,
	input  wire logic         res_valid,
	input  wire logic         res_stall,
	input  wire logic signed [31:0] value,
	input  wire logic [1:0]   status,
	output int                mismatches,
	output int                owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		word_t   value;
		status_t status;
	} outcome_t;

	outcome_t outcomes_due[$];

	// Evaluation state of one expression in flight.
	word_t       sum_acc;
	logic        sum_neg;
	word_t       num_acc;
	word_t       saved_sum_mem [NEST_DEPTH];
	logic        saved_neg_mem [NEST_DEPTH];
	int unsigned nest;
	status_t     err_code;

	initial begin
		mismatches = 0;
		owed = 0;
	end

	function automatic void clear_eval();
		sum_acc = '0;
		sum_neg = 1'b0;
		num_acc = '0;
		nest = 0;
		err_code = ST_OK;
	endfunction

	// Only the first error of an expression is reported.
	function automatic void note_error(status_t code);
		if (err_code == ST_OK) err_code = code;
	endfunction

	function automatic void fold_number();
		if (sum_neg) sum_acc = sum_acc - num_acc;
		else sum_acc = sum_acc + num_acc;
		num_acc = '0;
	endfunction

	function automatic void take_char(logic [7:0] c, logic fin);
		outcome_t fresh;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			num_acc = num_acc * 32'd10 + {24'd0, c - CH_ZERO};
			if (fin) fold_number();
		end else begin
			fold_number();
			case (c)
				CH_PLUS: sum_neg = 1'b0;
				CH_MINUS: sum_neg = 1'b1;
				CH_OPEN: begin
					if (nest >= NEST_DEPTH) begin
						note_error(ST_OVERFLOW);
					end else begin
						saved_sum_mem[nest] = sum_acc;
						saved_neg_mem[nest] = sum_neg;
						nest++;
						sum_acc = '0;
						sum_neg = 1'b0;
					end
				end
				CH_CLOSE: begin
					if (nest == 0) begin
						note_error(ST_UNMATCHED_CLOSE);
					end else begin
						nest--;
						if (saved_neg_mem[nest]) sum_acc = -sum_acc;
						sum_acc = sum_acc + saved_sum_mem[nest];
					end
				end
				default: ;
			endcase
		end
		if (fin) begin
			if (nest != 0) note_error(ST_UNCLOSED_OPEN);
			fresh.value = sum_acc;
			fresh.status = err_code;
			outcomes_due = {outcomes_due, fresh};
			clear_eval();
		end
	endfunction

	function automatic void check_result();
		outcome_t due;
		if (outcomes_due.size() == 0) begin
			$error("result with no expression pending: value %0d status %0d", value, status);
			mismatches++;
		end else begin
			due = outcomes_due.pop_front();
			if (value !== due.value) begin
				$error("value: expected %0d, actual %0d", $signed(due.value), value);
				mismatches++;
			end
			if (status !== due.status) begin
				$error("status: expected %0d, actual %0d", due.status, status);
				mismatches++;
			end
		end
	endfunction

	// The result is checked before the character of the same edge is taken:
	// a result can never stem from a character accepted at that very edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_eval();
			outcomes_due.delete();
			owed <= 0;
		end else begin
			if (res_valid && !res_stall) check_result();
			if (char_valid && !char_stall) take_char(char_code, last);
			owed <= outcomes_due.size();
		end
	end

endmodule : pmpe_checker

`default_nettype wire

// File: bench/plus_minus_paren_evaluator_unit_tb.sv
`default_nettype none

module plus_minus_paren_evaluator_unit_tb
	import pmpe_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NEST_DEPTH = 64;

	// The run is split by the number of characters sent: first the sender
	// idles lightly and the receiver heavily, then the reverse, then the
	// channels run flat out. The long receiver hold-off falls in the last part.
	localparam int CHAR_TARGET    = 2000;
	localparam int PHASE_TWO_AT   = 700;
	localparam int PHASE_THREE_AT = 1400;
	localparam int HOLD_AT        = 1600;
	localparam int HOLD_CYCLES    = 250;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              char_valid = 1'b0;
	logic              char_stall;
	logic [7:0]        char_code = '0;
	logic              last = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic signed [31:0] value;
	logic [1:0]        status;

	int mismatches;
	int owed;
	int chars_sent = 0;

	// The expression being assembled, one character per entry.
	logic [7:0] expr[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plus_minus_paren_evaluator_unit #(
		.NEST_DEPTH(NEST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value(value),
		.status(status)
	);

	pmpe_checker #(
		.NEST_DEPTH(NEST_DEPTH)
	) eval_check (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value(value),
		.status(status),
		.mismatches(mismatches),
		.owed(owed)
	);

	function automatic int sender_idle_pct();
		if (chars_sent < PHASE_TWO_AT) return 18;
		if (chars_sent < PHASE_THREE_AT) return 64;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (chars_sent < PHASE_TWO_AT) return 64;
		if (chars_sent < PHASE_THREE_AT) return 18;
		return 0;
	endfunction

	// Adds one character at the end of the expression.
	function automatic void append_char(logic [7:0] c);
		expr = {expr, c};
	endfunction

	// Offers one character and returns at the edge where it is transferred.
	// The payload stays put while the block stalls, and valid is set once per
	// step, so a back-to-back transfer never drops valid in between.
	task automatic put_char(input logic [7:0] c, input logic fin);
		while ($urandom_range(99) < sender_idle_pct()) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		last <= fin;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_expr();
		for (int k = 0; k < expr.size(); k++) put_char(expr[k], k == expr.size() - 1);
	endtask

	task automatic send_text(input string s);
		expr.delete();
		for (int k = 0; k < s.len(); k++) append_char(s[k]);
		send_expr();
	endtask

	// Stop offering and wait until every result owed has been transferred out.
	// It waits for a clock edge first so that the count already includes the
	// last character just sent.
	task automatic drain();
		char_valid <= 1'b0;
		@(posedge clk);
		wait (owed == 0);
		@(posedge clk);
	endtask

	// Mostly short numbers; now and then one long enough to wrap 32 bits.
	task automatic push_number();
		int digits;
		digits = ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
		repeat (digits) append_char(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic push_sign();
		append_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
	endtask

	// Spaces and arbitrary bytes that the block should skip; a random byte
	// may of course land on a digit or an operator, which is fine.
	task automatic maybe_noise();
		case ($urandom_range(15))
			0: append_char(" ");
			1: append_char(8'($urandom_range(255)));
			default: ;
		endcase
	endtask

	// A well-formed expression with random numbers, signs and nesting.
	task automatic build_balanced();
		int open_n;
		int tokens;
		open_n = 0;
		tokens = $urandom_range(1, 12);
		repeat (tokens) begin
			case ($urandom_range(5))
				0: begin
					if ($urandom_range(1)) push_sign();
					append_char(CH_OPEN);
					open_n++;
				end
				1: begin
					if (open_n > 0) begin
						append_char(CH_CLOSE);
						open_n--;
					end
				end
				default: begin
					if ($urandom_range(2) != 0) push_sign();
					push_number();
				end
			endcase
			maybe_noise();
		end
		while (open_n > 0) begin
			append_char(CH_CLOSE);
			open_n--;
		end
	endtask

	// Nesting close to and past the stack depth; sometimes left unclosed.
	task automatic build_deep();
		int levels;
		int closes;
		levels = $urandom_range(NEST_DEPTH - 3, NEST_DEPTH + 3);
		repeat (levels) begin
			push_number();
			push_sign();
			append_char(CH_OPEN);
		end
		push_number();
		closes = ($urandom_range(3) == 0) ? $urandom_range(levels) : levels;
		repeat (closes) append_char(CH_CLOSE);
	endtask

	// Broken sequences drawn mostly from the meaningful characters.
	task automatic build_broken();
		repeat ($urandom_range(1, 15)) begin
			case ($urandom_range(7))
				0, 1: append_char(CH_ZERO + 8'($urandom_range(9)));
				2: push_sign();
				3: append_char(CH_OPEN);
				4: append_char(CH_CLOSE);
				5: append_char(" ");
				default: append_char(8'($urandom_range(255)));
			endcase
		end
	endtask

	task automatic build_random();
		int pick;
		expr.delete();
		pick = $urandom_range(99);
		if (pick < 1) build_deep();
		else if (pick < 72) build_balanced();
		else if (pick < 88) build_broken();
		else repeat ($urandom_range(1, 6)) append_char(8'($urandom_range(255)));
		if (expr.size() == 0) push_number();
	endtask

	// Receiver: random stalls by phase, plus one long hold-off while the
	// sender keeps going, so that the block fills up and stalls its input.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && chars_sent >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= ($urandom_range(99) < receiver_idle_pct());
			end
		end
	end

	initial begin : stimulus
		bit drained;
		drained = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed cases: null and all-ones bytes alone, a lone digit as the
		// last character, a sign before a group, a plain sum, an unmatched
		// close, an unclosed open, both errors where the first must win, and
		// a number long enough to wrap.
		expr.delete();
		append_char(8'h00);
		send_expr();
		expr.delete();
		append_char(8'hff);
		send_expr();
		send_text("9");
		send_text("-(7)");
		send_text("1+2");
		send_text(")");
		send_text("(");
		send_text(")(");
		send_text("99999999999");

		// Sender pause: everything owed comes back before random traffic.
		drain();

		while (chars_sent < CHAR_TARGET) begin
			if (!drained && chars_sent >= PHASE_THREE_AT) begin
				drain();
				drained = 1'b1;
			end
			build_random();
			send_expr();
		end
		char_valid <= 1'b0;
		@(posedge clk);
		wait (owed == 0);
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin : watchdog
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule : plus_minus_paren_evaluator_unit_tb

`default_nettype wire

// File: sim.f
hdl/pmpe_pkg.sv
hdl/plus_minus_paren_evaluator_unit.sv
bench/pmpe_checker.sv
bench/plus_minus_paren_evaluator_unit_tb.sv
